// ===== design/polynomial_easing_curve_defines.svh =====
// Assertion macros used by the polynomial easing curve top level.
`ifndef POLYNOMIAL_EASING_CURVE_DEFINES_SVH
`define POLYNOMIAL_EASING_CURVE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a consequence in the same cycle as its cause.
`define PEC_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: consequence in the same cycle");

// Checks a consequence in the cycle after its cause.
`define PEC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: consequence in the next cycle");

`else

`define PEC_ASSERT_NOW(name, clk, rst, ante, cons)
`define PEC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/pec_pkg.sv =====
// Types, register indexes and the curve kind decoder of the easing curve block.
`default_nettype none

package pec_pkg;

  localparam int KIND_BITS      = 4;
  localparam int REG_INDEX_BITS = 2;

  localparam logic [REG_INDEX_BITS-1:0] REG_CURVE_KIND  = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_START_VALUE = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_END_VALUE   = 2'd2;

  typedef enum logic [1:0] {
    SHAPE_IN    = 2'd0,
    SHAPE_OUT   = 2'd1,
    SHAPE_INOUT = 2'd2
  } pec_shape_t;

  // Degree is held as n - 2, so 0 to 3 covers quadratic to quintic.
  typedef struct packed {
    logic [1:0] deg;
    pec_shape_t shape;
  } pec_kind_t;

  // Control that travels alongside each sample through the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] deg;
    pec_shape_t shape;
    logic       upper;
  } pec_ctl_t;

  // Kinds above the last defined one fall back to quintic in/out.
  function automatic pec_kind_t pec_decode(input logic [KIND_BITS-1:0] kind);
    pec_kind_t k;
    unique case (kind) inside
      4'd0:    k = '{deg: 2'd0, shape: SHAPE_IN};
      4'd1:    k = '{deg: 2'd0, shape: SHAPE_OUT};
      4'd2:    k = '{deg: 2'd0, shape: SHAPE_INOUT};
      4'd3:    k = '{deg: 2'd1, shape: SHAPE_IN};
      4'd4:    k = '{deg: 2'd1, shape: SHAPE_OUT};
      4'd5:    k = '{deg: 2'd1, shape: SHAPE_INOUT};
      4'd6:    k = '{deg: 2'd2, shape: SHAPE_IN};
      4'd7:    k = '{deg: 2'd2, shape: SHAPE_OUT};
      4'd8:    k = '{deg: 2'd2, shape: SHAPE_INOUT};
      4'd9:    k = '{deg: 2'd3, shape: SHAPE_IN};
      4'd10:   k = '{deg: 2'd3, shape: SHAPE_OUT};
      default: k = '{deg: 2'd3, shape: SHAPE_INOUT};
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/pec_if.sv =====
// Handshake interfaces for the position, result and register write channels.
`default_nettype none

interface pec_pos_if #(parameter int WIDTH = 17);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink (input valid, input position, output ready);
endinterface

interface pec_res_if #(parameter int WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] curve_value;

  modport source (output valid, output curve_value, input ready);
  modport sink (input valid, input curve_value, output ready);
endinterface

interface pec_cfg_if #(parameter int INDEX_BITS = 2, parameter int WIDTH = 16);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] reg_index;
  logic [WIDTH-1:0]      reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

// ===== design/pec_cfg_regs.sv =====
// Configuration registers: curve kind, start value and end value.
`default_nettype none

module pec_cfg_regs #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [pec_pkg::REG_INDEX_BITS-1:0]    wr_index,
  input  wire logic [VALUE_BITS-1:0]                 wr_data,
  output logic      [pec_pkg::KIND_BITS-1:0]         curve_kind,
  output logic signed [VALUE_BITS-1:0]               start_value,
  output logic signed [VALUE_BITS-1:0]               end_value
);
  import pec_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_kind  <= '0;
      start_value <= '0;
      end_value   <= {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CURVE_KIND:  curve_kind  <= wr_data[KIND_BITS-1:0];
        REG_START_VALUE: start_value <= wr_data;
        REG_END_VALUE:   end_value   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/pec_front.sv =====
// Front stages: position saturation, kind decode and base of the power chain.
`default_nettype none

module pec_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            adv,
  input  wire logic                            in_valid,
  input  wire logic [FRACTION_BITS:0]          position,
  input  wire logic [pec_pkg::KIND_BITS-1:0]   curve_kind,
  output pec_pkg::pec_ctl_t                    ctl_out,
  output logic      [FRACTION_BITS:0]          base
);
  import pec_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS:0] HALF = {2'b01, {(FRACTION_BITS-1){1'b0}}};

  pec_ctl_t                 ctl_a;
  logic [FRACTION_BITS:0]   pos_sat;
  pec_kind_t                kind;
  logic                     upper;
  logic [FRACTION_BITS:0]   from_one;
  logic [FRACTION_BITS:0]   base_next;

  assign kind = pec_decode(curve_kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (adv) begin
      ctl_a <= '{valid: in_valid, deg: kind.deg, shape: kind.shape, upper: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_sat <= (position > ONE) ? ONE : position;
    end
  end

  // The in/out form doubles its argument: 2p below one half, 2(1-p) from it on.
  assign upper    = (pos_sat >= HALF);
  assign from_one = ONE - pos_sat;

  always_comb begin
    case (ctl_a.shape)
      SHAPE_IN:    base_next = pos_sat;
      SHAPE_OUT:   base_next = from_one;
      SHAPE_INOUT: base_next = upper ? {from_one[FRACTION_BITS-1:0], 1'b0}
                                     : {pos_sat[FRACTION_BITS-1:0], 1'b0};
      default:     base_next = pos_sat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= '{valid: ctl_a.valid, deg: ctl_a.deg, shape: ctl_a.shape,
                   upper: upper};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      base <= base_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/pec_pow_stage.sv =====
// One multiply stage of the power chain, active when the degree reaches it.
`default_nettype none

module pec_pow_stage #(
  parameter int FRACTION_BITS = 16,
  parameter int STEP          = 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire pec_pkg::pec_ctl_t         ctl_in,
  input  wire logic [FRACTION_BITS:0]    r_in,
  input  wire logic [FRACTION_BITS:0]    x_in,
  output pec_pkg::pec_ctl_t              ctl_out,
  output logic      [FRACTION_BITS:0]    r_out,
  output logic      [FRACTION_BITS:0]    x_out
);
  import pec_pkg::*;

  logic [2*FRACTION_BITS+1:0] prod;
  logic                       active;

  // Step k forms x^(k+1), needed only when the degree n exceeds k.
  assign active = (ctl_in.deg >= 2'(STEP - 1));
  assign prod   = r_in * x_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_out <= active ? prod[2*FRACTION_BITS:FRACTION_BITS] : r_in;
      x_out <= x_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/pec_back.sv =====
// Back stages: curve fraction, scaling by the value span, rounding and offset.
`default_nettype none

module pec_back #(
  parameter int FRACTION_BITS = 16,
  parameter int VALUE_BITS    = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire pec_pkg::pec_ctl_t              ctl_in,
  input  wire logic [FRACTION_BITS:0]         r_in,
  input  wire logic signed [VALUE_BITS-1:0]   start_value,
  input  wire logic signed [VALUE_BITS-1:0]   end_value,
  output logic                                res_valid,
  output logic signed [VALUE_BITS-1:0]        curve_value
);
  import pec_pkg::*;

  localparam int PW = VALUE_BITS + FRACTION_BITS + 4;
  localparam logic [FRACTION_BITS:0]   ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [FRACTION_BITS+1:0] TWO = {1'b1, {(FRACTION_BITS+1){1'b0}}};
  localparam logic signed [PW-1:0]     ROUND_BIAS = PW'(ONE);

  pec_ctl_t                   ctl_f;
  pec_ctl_t                   ctl_m;
  logic [FRACTION_BITS+1:0]   f2_next;
  logic [FRACTION_BITS+1:0]   f2;
  logic [FRACTION_BITS:0]     one_minus;
  logic signed [VALUE_BITS:0] diff;
  logic signed [FRACTION_BITS+2:0] f2_s;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       rsum;
  logic signed [PW-1:0]       q;

  // The fraction is kept doubled so that the in/out halving stays exact.
  assign one_minus = ONE - r_in;

  always_comb begin
    case (ctl_in.shape)
      SHAPE_IN:    f2_next = {r_in, 1'b0};
      SHAPE_OUT:   f2_next = {one_minus, 1'b0};
      SHAPE_INOUT: f2_next = ctl_in.upper ? (TWO - {1'b0, r_in}) : {1'b0, r_in};
      default:     f2_next = {r_in, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_f <= '0;
      ctl_m <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      ctl_f <= ctl_in;
      ctl_m <= ctl_f;
      res_valid <= ctl_m.valid;
    end
  end

  assign diff = {end_value[VALUE_BITS-1], end_value}
              - {start_value[VALUE_BITS-1], start_value};
  assign f2_s = $signed({1'b0, f2});

  // Adding one half LSB and flooring rounds half toward plus infinity.
  assign rsum = prod + ROUND_BIAS;
  assign q    = rsum >>> (FRACTION_BITS + 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      f2          <= f2_next;
      prod        <= PW'(diff) * PW'(f2_s);
      curve_value <= start_value + q[VALUE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/polynomial_easing_curve.sv =====
// Top level of the polynomial easing curve evaluator.
//
//   channel   dir   payload                      request taken when
//   pos       in    position                     pos.valid & pos.ready
//   res       out   curve_value                  res.valid & res.ready
//   cfg       in    reg_index, reg_data          cfg.valid & cfg.ready
//
// One sample enters per cycle unless res stalls; each result passes through the nine register
// stages (two front, four multiply, three back).
// The four multiply stages raise the base to the power n, one multiply per stage used.
// rst is synchronous, clears the valid bits and resets the configuration registers.
// A stall on res freezes the whole pipeline; pos.ready is low only then.
`default_nettype none

`include "polynomial_easing_curve_defines.svh"

module polynomial_easing_curve #(
  parameter int FRACTION_BITS = 16,
  parameter int VALUE_BITS    = 16
) (
  input wire logic clk,
  input wire logic rst,
  pec_pos_if.sink   pos,
  pec_res_if.source res,
  pec_cfg_if.sink   cfg
);
  import pec_pkg::*;

  localparam int POW_STEPS = 4;

  logic                           adv;
  logic [KIND_BITS-1:0]           curve_kind;
  logic signed [VALUE_BITS-1:0]   start_value;
  logic signed [VALUE_BITS-1:0]   end_value;
  pec_ctl_t                       ctl_pow [0:POW_STEPS];
  logic [FRACTION_BITS:0]         r_pow   [0:POW_STEPS];
  logic [FRACTION_BITS:0]         x_pow   [0:POW_STEPS];

  assign adv       = !res.valid || res.ready;
  assign pos.ready = adv;
  assign cfg.ready = 1'b1;

  pec_cfg_regs #(.VALUE_BITS(VALUE_BITS)) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg.valid),
    .wr_index    (cfg.reg_index),
    .wr_data     (cfg.reg_data),
    .curve_kind  (curve_kind),
    .start_value (start_value),
    .end_value   (end_value)
  );

  pec_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (pos.valid),
    .position   (pos.position),
    .curve_kind (curve_kind),
    .ctl_out    (ctl_pow[0]),
    .base       (x_pow[0])
  );

  assign r_pow[0] = x_pow[0];

  for (genvar i = 1; i <= POW_STEPS; i++) begin : g_pow
    pec_pow_stage #(.FRACTION_BITS(FRACTION_BITS), .STEP(i)) u_pow (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (ctl_pow[i-1]),
      .r_in    (r_pow[i-1]),
      .x_in    (x_pow[i-1]),
      .ctl_out (ctl_pow[i]),
      .r_out   (r_pow[i]),
      .x_out   (x_pow[i])
    );
  end

  pec_back #(.FRACTION_BITS(FRACTION_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .ctl_in      (ctl_pow[POW_STEPS]),
    .r_in        (r_pow[POW_STEPS]),
    .start_value (start_value),
    .end_value   (end_value),
    .res_valid   (res.valid),
    .curve_value (res.curve_value)
  );

  // Input is refused only while a finished result is held back by the sink.
  `PEC_ASSERT_NOW(a_ready_only_on_stall, clk, rst, !pos.ready, res.valid && !res.ready)

  // A stalled pipeline keeps the sample at the end of the power chain.
  `PEC_ASSERT_NEXT(a_stall_holds_chain, clk, rst, !adv,
    ctl_pow[POW_STEPS] == $past(ctl_pow[POW_STEPS]) && r_pow[POW_STEPS] == $past(r_pow[POW_STEPS]))

endmodule

`default_nettype wire

// ===== verif/tb_polynomial_easing_curve.sv =====
// Self-checking testbench for the polynomial easing curve evaluator.
`timescale 1ns / 1ps

module tb_polynomial_easing_curve;
  import pec_pkg::*;

  localparam int POS_BITS    = 17;
  localparam int VALUE_W     = 16;
  localparam int LATENCY     = 9;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_LIMIT = 50;

  typedef struct {
    logic [POS_BITS-1:0]       position;
    logic signed [VALUE_W-1:0] value;
  } curve_expect_t;

  // Tracks the register settings and holds the expected curve values in request order.
  class curve_value_board;
    localparam longint unsigned UNITY = 64'd1 << 16;
    localparam int ROUND_SHIFT = 17;

    logic [KIND_BITS-1:0]      kind_reg;
    logic signed [VALUE_W-1:0] start_reg;
    logic signed [VALUE_W-1:0] end_reg;
    curve_expect_t             expected_values[$];

    function new();
      kind_reg  = '0;
      start_reg = '0;
      end_reg   = 16'sh7fff;
    endfunction

    function void apply_register(logic [REG_INDEX_BITS-1:0] index, logic [VALUE_W-1:0] data);
      case (index)
        REG_CURVE_KIND:  kind_reg = data[KIND_BITS-1:0];
        REG_START_VALUE: start_reg = data;
        REG_END_VALUE:   end_reg = data;
        default: ;
      endcase
    endfunction

    // Power in Q1.16, truncating after every multiply.
    function longint unsigned fixed_power(longint unsigned x, int degree);
      longint unsigned acc;
      acc = x;
      for (int i = 1; i < degree; i++) acc = (acc * x) >> 16;
      return acc;
    endfunction

    function logic signed [VALUE_W-1:0] eased_value(logic [POS_BITS-1:0] position);
      longint unsigned p;
      longint unsigned twice_f;
      int unsigned     kind;
      int              degree;
      pec_shape_t      shape;
      longint          base;
      longint          span;
      longint          prod;
      longint          step;
      longint          total;
      p = position;
      if (p > UNITY) p = UNITY;
      kind = (kind_reg > 11) ? 11 : kind_reg;
      degree = kind / 3 + 2;
      shape = pec_shape_t'(kind % 3);
      // The eased fraction is kept doubled so that the in/out halving stays exact.
      case (shape)
        SHAPE_IN:  twice_f = fixed_power(p, degree) << 1;
        SHAPE_OUT: twice_f = (UNITY - fixed_power(UNITY - p, degree)) << 1;
        default: begin
          if (p < (UNITY >> 1)) twice_f = fixed_power(p << 1, degree);
          else twice_f = (UNITY << 1) - fixed_power((UNITY - p) << 1, degree);
        end
      endcase
      base = longint'(start_reg);
      span = longint'(end_reg) - base;
      prod = span * longint'(twice_f) + longint'(UNITY);
      step = prod >>> ROUND_SHIFT;
      total = base + step;
      return total[VALUE_W-1:0];
    endfunction

    function void note_request(logic [POS_BITS-1:0] position);
      curve_expect_t e;
      e.position = position;
      e.value    = eased_value(position);
      expected_values.push_back(e);
    endfunction

    function bit check_result(logic signed [VALUE_W-1:0] got, output string msg);
      curve_expect_t e;
      msg = "";
      if (expected_values.size() == 0) begin
        msg = $sformatf("curve_value %0d arrived with no request waiting", got);
        return 0;
      end
      e = expected_values.pop_front();
      if (got !== e.value) begin
        msg = $sformatf("curve_value got %0d expected %0d for position %h",
                        got, e.value, e.position);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return expected_values.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  curve_value_board board = new();

  pec_pos_if #(.WIDTH(POS_BITS)) pos_ch ();
  pec_res_if #(.WIDTH(VALUE_W))  res_ch ();
  pec_cfg_if #(.INDEX_BITS(REG_INDEX_BITS), .WIDTH(VALUE_W)) cfg_ch ();

  polynomial_easing_curve uut (
    .clk (clk),
    .rst (rst),
    .pos (pos_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // All handshakes are sampled on pre-edge values, so results are checked before new requests.
  always @(posedge clk) begin
    string msg;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (!board.check_result(res_ch.curve_value, msg)) report_mismatch(msg);
      end
      if (pos_ch.valid && pos_ch.ready) board.note_request(pos_ch.position);
      if (cfg_ch.valid && cfg_ch.ready) board.apply_register(cfg_ch.reg_index, cfg_ch.reg_data);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 6))
        0: return 17'd0;
        1: return 17'd1;
        2: return 17'd32767;
        3: return 17'd32768;
        4: return 17'd32769;
        5: return 17'd65535;
        default: return 17'd65536;
      endcase
    end
    if (r < 25) return POS_BITS'($urandom_range(65537, 131071));
    return POS_BITS'($urandom_range(0, 65536));
  endfunction

  // Receiver: runs of ready with random stalls in between.
  initial begin
    int unsigned stall;
    res_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_position(input logic [POS_BITS-1:0] position);
    int unsigned gap;
    pos_ch.valid    <= 1'b1;
    pos_ch.position <= position;
    do @(posedge clk); while (!pos_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      pos_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [REG_INDEX_BITS-1:0] index,
                                input logic [VALUE_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.reg_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops requests and waits until every expected value has come back.
  task automatic drain();
    pos_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic set_curve(input logic [VALUE_W-1:0] kind_data, input logic [VALUE_W-1:0] lo,
                           input logic [VALUE_W-1:0] hi);
    drain();
    repeat (LATENCY + 3) @(posedge clk);
    write_register(REG_CURVE_KIND, kind_data);
    write_register(REG_START_VALUE, lo);
    write_register(REG_END_VALUE, hi);
  endtask

  initial begin
    logic [POS_BITS-1:0] reset_corners[] = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65535,
                                             17'd65536, 17'd65537, 17'd131071};
    logic [POS_BITS-1:0] mid_corners[]   = '{17'd32767, 17'd32768, 17'd32769, 17'd0, 17'd65536};
    logic [POS_BITS-1:0] clamp_corners[] = '{17'd32768, 17'd1, 17'd65535, 17'd98304};
    logic [VALUE_W-1:0]  kind_data;
    int unsigned         count;

    rst              = 1'b1;
    quiet            = 1'b0;
    pos_ch.valid     = 1'b0;
    pos_ch.position  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_CURVE_KIND;
    cfg_ch.reg_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: quadratic ease in over the full positive range.
    foreach (reset_corners[i]) send_position(reset_corners[i]);

    // Quadratic in/out across the whole value range, around the midpoint.
    set_curve(16'd2, 16'h8000, 16'h7fff);
    foreach (mid_corners[i]) send_position(mid_corners[i]);

    // Undefined kinds fall back to quintic in/out; falling curve.
    set_curve(16'd15, 16'h7fff, 16'h8000);
    foreach (clamp_corners[i]) send_position(clamp_corners[i]);

    for (int ph = 0; ph < 32; ph++) begin
      kind_data = VALUE_W'(ph % 16);
      if (ph >= 16 && $urandom_range(0, 1))
        kind_data[VALUE_W-1:KIND_BITS] = (VALUE_W-KIND_BITS)'($urandom);
      set_curve(kind_data, pick_level(), pick_level());
      // The unused register slot must not disturb anything.
      if (ph == 5) write_register(REG_INDEX_BITS'(3), VALUE_W'($urandom_range(0, 65535)));
      quiet = (ph % 5 == 4);
      count = $urandom_range(40, 66);
      for (int i = 0; i < count; i++) begin
        send_position(pick_position());
        if (ph % 7 == 3 && i == count / 2) drain();
      end
    end

    quiet = 1'b0;
    drain();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/pec_pkg.sv
design/pec_if.sv
design/pec_cfg_regs.sv
design/pec_front.sv
design/pec_pow_stage.sv
design/pec_back.sv
design/polynomial_easing_curve.sv
verif/tb_polynomial_easing_curve.sv
